// ===== design/arpc_pkg.sv =====
// Package for the ARP cache engine: shared types, codes and constants.
// Used by the interfaces, the controller, the datapath and the top level.
package arpc_pkg;

  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned AGE_W  = 20;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned OPC_W  = 16;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned ADDR_W = 5;

  // Ethernet header plus ARP body
  localparam logic [LEN_W-1:0] MIN_FRAME   = LEN_W'(14 + 28);
  localparam logic [OPC_W-1:0] OPC_REQUEST = OPC_W'(1);
  localparam logic [AGE_W-1:0] AGE_RESET   = AGE_W'(600000);
  localparam logic [AGE_W-1:0] AGE_MAX     = '1;

  typedef enum logic [1:0] {
    OP_PKT     = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_REPLY   = 2'd1,
    SEND_REQUEST = 2'd2
  } send_e;

  typedef enum logic [1:0] {
    REG_OWN_IP    = 2'd0,
    REG_OWN_MAC   = 2'd1,
    REG_AGE_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LEARN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic learn_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic is_pkt;
    logic all_issued;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ===== design/arpc_req_if.sv =====
// Request channel of the ARP cache engine: valid/ready plus one operation.
// Depends on arpc_pkg for field widths.
interface arpc_req_if import arpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [LEN_W-1:0] frame_length;
  logic [OPC_W-1:0] arp_opcode;
  logic [IP_W-1:0]  sender_ip;
  logic [MAC_W-1:0] sender_mac;
  logic [IP_W-1:0]  query_ip;

  modport source (output valid, operation, frame_length, arp_opcode, sender_ip,
                  sender_mac, query_ip, input ready);
  modport sink   (input valid, operation, frame_length, arp_opcode, sender_ip,
                  sender_mac, query_ip, output ready);
endinterface

// ===== design/arpc_rsp_if.sv =====
// Result channel of the ARP cache engine: valid/ready plus one result.
// Depends on arpc_pkg for field widths.
interface arpc_rsp_if import arpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] found_mac;
  logic [1:0]       send_kind;
  logic [MAC_W-1:0] peer_mac;
  logic [IP_W-1:0]  peer_ip;

  modport source (output valid, hit, found_mac, send_kind, peer_mac, peer_ip,
                  input ready);
  modport sink   (input valid, hit, found_mac, send_kind, peer_mac, peer_ip,
                  output ready);
endinterface

// ===== design/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/arpc_ctrl.sv =====
// Controller of the ARP cache engine: sequences capture, table walk,
// learn write and result hand-off. Depends on arpc_pkg.
module arpc_ctrl import arpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.drop) begin
          state_d = S_DONE;
        end else if (status_i.last) begin
          state_d = status_i.is_pkt ? S_LEARN : S_DONE;
        end
      end
      S_LEARN: state_d = S_DONE;
      S_DONE: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o    = (state_q == S_IDLE);
    cmd_o.capture  = (state_q == S_IDLE) && req_valid_i;
    cmd_o.issue    = (state_q == S_SCAN) && !status_i.all_issued && !status_i.drop;
    cmd_o.learn_wr = (state_q == S_LEARN);
    cmd_o.load_out = (state_q == S_DONE) && status_i.out_free;
  end

  a_capture_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_SCAN)
    else $error("capture did not start a table walk");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded over an unread one");

  a_learn_only_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEARN) |-> $past(status_i.is_pkt && !status_i.drop))
    else $error("learn step without a long packet");

endmodule

// ===== design/arpc_datapath.sv =====
// Datapath of the ARP cache engine: request and config operands, table RAM,
// valid marks, walk counters, search results and the output register.
// Depends on arpc_pkg and arpc_ram.
module arpc_datapath import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic [1:0]       operation_i,
  input  logic [LEN_W-1:0] frame_length_i,
  input  logic [OPC_W-1:0] arp_opcode_i,
  input  logic [IP_W-1:0]  sender_ip_i,
  input  logic [MAC_W-1:0] sender_mac_i,
  input  logic [IP_W-1:0]  query_ip_i,
  input  logic [IP_W-1:0]  own_ip_i,
  input  logic [AGE_W-1:0] age_limit_i,
  input  logic             rsp_ready_i,
  output logic             rsp_valid_o,
  output logic             hit_o,
  output logic [MAC_W-1:0] found_mac_o,
  output logic [1:0]       send_kind_o,
  output logic [MAC_W-1:0] peer_mac_o,
  output logic [IP_W-1:0]  peer_ip_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // captured request
  op_e              op_q;
  logic [LEN_W-1:0] flen_q;
  logic [OPC_W-1:0] opc_q;
  logic [IP_W-1:0]  sip_q;
  logic [MAC_W-1:0] smac_q;
  logic [IP_W-1:0]  tip_q;

  // walk state
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic               rdv_q;
  logic [IW-1:0]      dix_q;
  logic [ENTRIES-1:0] vld_q, vld_d;
  logic               mfound_q, mfound_d;
  logic               ffound_q, ffound_d;
  logic [IW-1:0]      midx_q, fidx_q;
  logic [MAC_W-1:0]   mmac_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             hit_q;
  logic [MAC_W-1:0] fmac_q;
  send_e            kind_q;
  logic [MAC_W-1:0] pmac_q;
  logic [IP_W-1:0]  pip_q;

  logic [$bits(entry_t)-1:0] ram_rdata, ram_wdata;
  logic [IW-1:0]             ram_waddr;
  logic                      ram_we;
  entry_t                    row, wrow;
  logic [IP_W-1:0]           key;
  logic                      is_match, is_free, tick_we, expire, drop;
  logic [AGE_W-1:0]          age_inc;
  logic [IW-1:0]             slot;

  logic             res_hit;
  logic [MAC_W-1:0] res_fmac, res_pmac;
  send_e            res_kind;
  logic [IP_W-1:0]  res_pip;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(operation_i);
      flen_q <= frame_length_i;
      opc_q  <= arp_opcode_i;
      sip_q  <= sender_ip_i;
      smac_q <= sender_mac_i;
      tip_q  <= query_ip_i;
    end
    if (cmd_i.issue) begin
      dix_q <= rd_cnt_q[IW-1:0];
    end
    if (is_match && !mfound_q) begin
      midx_q <= dix_q;
      mmac_q <= row.mac;
    end
    if (is_free && !ffound_q) begin
      fidx_q <= dix_q;
    end
    if (cmd_i.load_out) begin
      hit_q  <= res_hit;
      fmac_q <= res_fmac;
      kind_q <= res_kind;
      pmac_q <= res_pmac;
      pip_q  <= res_pip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q    <= '0;
      rdv_q       <= 1'b0;
      vld_q       <= '0;
      mfound_q    <= 1'b0;
      ffound_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_cnt_q    <= rd_cnt_d;
      rdv_q       <= cmd_i.issue;
      vld_q       <= vld_d;
      mfound_q    <= mfound_d;
      ffound_q    <= ffound_d;
      out_valid_q <= out_valid_d;
    end
  end

  arpc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // search and ageing on the entry read back this cycle
  always_comb begin
    row      = entry_t'(ram_rdata);
    key      = (op_q == OP_PKT) ? sip_q : tip_q;
    is_match = rdv_q && vld_q[dix_q] && (row.ip == key);
    is_free  = rdv_q && !vld_q[dix_q];
    age_inc  = (row.age == AGE_MAX) ? row.age : row.age + AGE_W'(1);
    expire   = age_inc > age_limit_i;
    tick_we  = rdv_q && (op_q == OP_TICK) && vld_q[dix_q];
    drop     = (op_q == OP_PKT) && (flen_q < MIN_FRAME);
    slot     = mfound_q ? midx_q : (ffound_q ? fidx_q : '0);
  end

  always_comb begin
    wrow      = '{ip: row.ip, mac: row.mac, age: age_inc};
    ram_waddr = dix_q;
    if (cmd_i.learn_wr) begin
      wrow      = '{ip: sip_q, mac: smac_q, age: '0};
      ram_waddr = slot;
    end
    ram_we    = tick_we || cmd_i.learn_wr;
    ram_wdata = wrow;
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    mfound_d = mfound_q || is_match;
    ffound_d = ffound_q || is_free;
    vld_d    = vld_q;
    if (cmd_i.capture) begin
      rd_cnt_d = '0;
      mfound_d = 1'b0;
      ffound_d = 1'b0;
    end else if (cmd_i.issue) begin
      rd_cnt_d = rd_cnt_q + CW'(1);
    end
    if (tick_we && expire) vld_d[dix_q] = 1'b0;
    if (cmd_i.learn_wr)    vld_d[slot]  = 1'b1;
  end

  // result of the finished item
  always_comb begin
    res_hit  = 1'b0;
    res_fmac = '0;
    res_kind = SEND_NONE;
    res_pmac = '0;
    res_pip  = '0;
    unique case (op_q)
      OP_PKT: begin
        if (!drop && (opc_q == OPC_REQUEST) && (tip_q == own_ip_i) && (own_ip_i != '0)) begin
          res_kind = SEND_REPLY;
          res_pmac = smac_q;
          res_pip  = sip_q;
        end
      end
      OP_LOOKUP, OP_RESOLVE: begin
        if (mfound_q) begin
          res_hit  = 1'b1;
          res_fmac = mmac_q;
        end else if (op_q == OP_RESOLVE) begin
          res_kind = SEND_REQUEST;
          res_pip  = tip_q;
        end
      end
      OP_TICK: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign status_o.drop       = drop;
  assign status_o.is_pkt     = (op_q == OP_PKT);
  assign status_o.all_issued = (rd_cnt_q == CW'(ENTRIES));
  assign status_o.last       = rdv_q && (dix_q == IW'(ENTRIES - 1));
  assign status_o.out_free   = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign found_mac_o = fmac_q;
  assign send_kind_o = kind_q;
  assign peer_mac_o  = pmac_q;
  assign peer_ip_o   = pip_q;

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tick_we && cmd_i.learn_wr))
    else $error("ageing write and learn write collide");

  a_learn_long_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.learn_wr |-> (op_q == OP_PKT) && !drop)
    else $error("learn write for an item that does not learn");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |=> rd_cnt_q <= CW'(ENTRIES))
    else $error("table walk ran past the last entry");

endmodule

// ===== design/arp_cache_engine.sv =====
// ARP cache engine top level: config registers, controller and datapath.
// Requests are taken one at a time. Each walks the table with one RAM read per
// cycle; a packet then learns its sender, while a short (dropped) packet skips
// the walk. An unread result holds the next one. Reset clears all valid marks
// at once.
module arp_cache_engine import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  arpc_req_if.sink          req_i,
  arpc_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  // Configuration registers. Register i sits at byte address 8*i since
  // own_mac needs the wide data bus; the low address bits are ignored.
  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;
  logic [AGE_W-1:0] age_limit_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  cmd_t    cmd;
  status_t status;
  logic    req_ready;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[4:3]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q    <= '0;
      own_mac_q   <= '0;
      age_limit_q <= AGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OWN_IP:    own_ip_q    <= pwdata[IP_W-1:0];
        REG_OWN_MAC:   own_mac_q   <= pwdata[MAC_W-1:0];
        REG_AGE_LIMIT: age_limit_q <= pwdata[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // read back: zero-extend to the bus width, unmapped slot reads zero
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_OWN_IP:    prdata = CFG_W'(own_ip_q);
      REG_OWN_MAC:   prdata = CFG_W'(own_mac_q);
      REG_AGE_LIMIT: prdata = CFG_W'(age_limit_q);
      default:       prdata = '0;
    endcase
  end

  // Controller: takes a request only when idle, walks the table, then
  // hands the result to the output register, which frees it to take the
  // next request while the result still waits.
  arpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // Datapath: table RAM, valid marks, search results and output register.
  arpc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (req_i.operation),
    .frame_length_i (req_i.frame_length),
    .arp_opcode_i   (req_i.arp_opcode),
    .sender_ip_i    (req_i.sender_ip),
    .sender_mac_i   (req_i.sender_mac),
    .query_ip_i     (req_i.query_ip),
    .own_ip_i       (own_ip_q),
    .age_limit_i    (age_limit_q),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .hit_o          (rsp_o.hit),
    .found_mac_o    (rsp_o.found_mac),
    .send_kind_o    (rsp_o.send_kind),
    .peer_mac_o     (rsp_o.peer_mac),
    .peer_ip_o      (rsp_o.peer_ip)
  );

endmodule
